>>> rtl/core/mbc1bm_pkg.sv
package mbc1bm_pkg;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_ROM_READ  = 2'd1,
    KIND_RAM_READ  = 2'd2,
    KIND_RAM_WRITE = 2'd3
  } access_kind_t;

  typedef enum logic [1:0] {
    RAM_NONE   = 2'd0,
    RAM_2K     = 2'd1,
    RAM_8K     = 2'd2,
    RAM_32K    = 2'd3
  } ram_kind_t;

  typedef enum logic {
    REG_ROM_BANKS_LOG2 = 1'b0,
    REG_RAM_KIND       = 1'b1
  } cfg_reg_t;

  // address[15:13] regions, write and read views share codes
  typedef logic [2:0] region_t;

  localparam region_t REGION_RAM_ENABLE = 3'd0;
  localparam region_t REGION_ROM_BANK   = 3'd1;
  localparam region_t REGION_UPPER_BANK = 3'd2;
  localparam region_t REGION_MODE       = 3'd3;
  localparam region_t REGION_SWITCH_LO  = 3'd2;
  localparam region_t REGION_SWITCH_HI  = 3'd3;
  localparam region_t REGION_VIDEO      = 3'd4;
  localparam region_t REGION_EXT_RAM    = 3'd5;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MAPPED_W  = 21;
  localparam int unsigned BANK_W    = 7;
  localparam int unsigned LOW5_W    = 5;
  localparam int unsigned OFFSET_W  = 14;
  localparam int unsigned LOG2_W    = 3;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

>>> rtl/core/mbc1_bank_mapper.sv
// MBC1-style bank controller: translates CPU bus accesses to ROM/RAM addresses.
// s_axis: one access per beat; tuser = req_type (0 read, 1 write),
//   tdata = bus_address [15:0], write_byte [23:16].
// m_axis: one translated access per input beat; tuser = access_kind
//   (0 none/open bus, 1 ROM read, 2 RAM read, 3 RAM write),
//   tdata = mapped_address [20:0], ram_write_byte [28:21].
// cfg: register writes, index 0 rom_banks_log2, index 1 ram_kind; always ready.
//   write config only while no access is in flight.
// The output beat is registered and appears in the cycle after the input beat; throughput
// is one beat per cycle while the output is not stalled, limited by the single output register.
// Writes below 0x8000 update the bank registers at the accepting edge, so the
// next beat already sees the new mapping.
// Reset (rst, synchronous) empties the output register and restores bank 1,
// RAM disabled, mode 0, two ROM banks and no RAM.
// When m_axis_tready is low the result holds and s_axis_tready drops; a new
// beat is still taken in the cycle the held result leaves.
module mbc1_bank_mapper #(
  parameter int unsigned MAX_ROM_BANKS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bus_address, write_byte
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // mapped_address, ram_write_byte, zero pad
  output logic [1:0]  m_axis_tuser,  // access_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);
  import mbc1bm_pkg::*;

  localparam int unsigned CountW = 8;

  logic [LOG2_W-1:0] rom_banks_log2;
  ram_kind_t         ram_kind;
  logic              ram_enabled;
  logic [LOW5_W-1:0] rom_bank_low5;
  logic [1:0]        upper_bank_bits;
  logic              banking_mode;

  logic [ADDR_W-1:0] bus_address;
  logic [BYTE_W-1:0] write_byte;
  logic              is_write;
  logic              accept;
  region_t           region;

  logic [LOG2_W-1:0] log2_eff;
  logic [CountW-1:0] bank_count;
  logic [CountW-1:0] bank_mask;
  logic [BANK_W-1:0] zero_region_bank;
  logic [BANK_W-1:0] switch_region_bank;
  logic [LOW5_W-1:0] low5_next;

  logic              ram_hit;
  logic [MAPPED_W-1:0] ram_address;
  access_kind_t      kind_next;
  logic [MAPPED_W-1:0] mapped_next;
  logic [BYTE_W-1:0] wbyte_next;

  access_kind_t      access_kind;
  logic [MAPPED_W-1:0] mapped_address;
  logic [BYTE_W-1:0] ram_write_byte;

  assign bus_address   = s_axis_tdata[ADDR_W-1:0];
  assign write_byte    = s_axis_tdata[ADDR_W +: BYTE_W];
  assign is_write      = s_axis_tuser;
  assign region        = region_t'(bus_address[ADDR_W-1 -: 3]);
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // bank count and derived banks
  always_comb begin
    log2_eff = (rom_banks_log2 == '0) ? LOG2_W'(1) : rom_banks_log2;
    bank_count = CountW'(1) << log2_eff;
    if (bank_count > CountW'(MAX_ROM_BANKS)) begin
      bank_count = CountW'(MAX_ROM_BANKS);
    end
    bank_mask = bank_count - CountW'(1);
    switch_region_bank = {upper_bank_bits, rom_bank_low5} & bank_mask[BANK_W-1:0];
    zero_region_bank   = {upper_bank_bits, LOW5_W'(0)} & bank_mask[BANK_W-1:0];
    low5_next = write_byte[LOW5_W-1:0];
    if (low5_next == '0) begin
      low5_next = LOW5_W'(1);
    end
  end

  // external RAM mapping
  always_comb begin
    ram_hit     = ram_enabled;
    ram_address = '0;
    case (ram_kind)
      RAM_2K:  ram_address = MAPPED_W'(bus_address[10:0]);
      RAM_8K:  ram_address = MAPPED_W'(bus_address[12:0]);
      RAM_32K: begin
        if (banking_mode) begin
          ram_address = MAPPED_W'({upper_bank_bits, bus_address[12:0]});
        end else begin
          ram_address = MAPPED_W'(bus_address[12:0]);
        end
      end
      default: ram_hit = 1'b0;
    endcase
  end

  // result of the current beat
  always_comb begin
    kind_next   = KIND_NONE;
    mapped_next = '0;
    wbyte_next  = '0;
    if (is_write) begin
      if (region == REGION_EXT_RAM && ram_hit) begin
        kind_next   = KIND_RAM_WRITE;
        mapped_next = ram_address;
        wbyte_next  = write_byte;
      end
    end else begin
      case (region)
        REGION_RAM_ENABLE, REGION_ROM_BANK: begin
          kind_next = KIND_ROM_READ;
          if (banking_mode) begin
            mapped_next = {zero_region_bank, bus_address[OFFSET_W-1:0]};
          end else begin
            mapped_next = MAPPED_W'(bus_address);
          end
        end
        REGION_SWITCH_LO, REGION_SWITCH_HI: begin
          kind_next   = KIND_ROM_READ;
          mapped_next = {switch_region_bank, bus_address[OFFSET_W-1:0]};
        end
        REGION_EXT_RAM: begin
          if (ram_hit) begin
            kind_next   = KIND_RAM_READ;
            mapped_next = ram_address;
          end
        end
        default: kind_next = KIND_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_banks_log2  <= LOG2_W'(1);
      ram_kind        <= RAM_NONE;
      ram_enabled     <= 1'b0;
      rom_bank_low5   <= LOW5_W'(1);
      upper_bank_bits <= '0;
      banking_mode    <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROM_BANKS_LOG2: rom_banks_log2 <= cfg_data;
          REG_RAM_KIND:       ram_kind <= ram_kind_t'(cfg_data[1:0]);
          default:            ram_kind <= ram_kind;
        endcase
      end
      if (accept && is_write) begin
        case (region)
          REGION_RAM_ENABLE: ram_enabled <= (write_byte[3:0] == RAM_ENABLE_KEY);
          REGION_ROM_BANK:   rom_bank_low5 <= low5_next;
          REGION_UPPER_BANK: upper_bank_bits <= write_byte[1:0];
          REGION_MODE:       banking_mode <= write_byte[0];
          default:           banking_mode <= banking_mode;
        endcase
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      access_kind    <= kind_next;
      mapped_address <= mapped_next;
      ram_write_byte <= wbyte_next;
    end
  end

  assign m_axis_tuser = access_kind;
  assign m_axis_tdata = {{(M_TDATA_W - MAPPED_W - BYTE_W){1'b0}}, ram_write_byte,
                         mapped_address};

endmodule

>>> sim/mbc1_bank_mapper_test.sv
`timescale 1ns / 1ps

module mbc1_bank_mapper_test;
  import mbc1bm_pkg::*;

  localparam int ROM_BANK_LIMIT = 128;

  class bank_scoreboard;
    typedef struct {
      access_kind_t kind;
      logic [20:0]  addr;
      logic [7:0]   data;
    } translation_t;

    translation_t expected[$];
    logic [2:0]   banks_log2  = 3'd1;
    ram_kind_t    ram_sel     = RAM_NONE;
    logic         ram_on      = 1'b0;
    logic [4:0]   low5        = 5'd1;
    logic [1:0]   upper       = 2'd0;
    logic         mode        = 1'b0;
    logic [6:0]   zero_bank   = 7'd0;
    logic [6:0]   switch_bank = 7'd1;
    int           errors      = 0;
    int           checked     = 0;

    function int pending();
      return expected.size();
    endfunction

    function void derive_banks();
      int         lg;
      int         count;
      logic [6:0] mask;
      logic [6:0] up;
      lg = (banks_log2 == 3'd0) ? 1 : int'(banks_log2);
      count = 1 << lg;
      if (count > ROM_BANK_LIMIT) count = ROM_BANK_LIMIT;
      mask = 7'(count - 1);
      up = {upper, 5'd0};
      switch_bank = (up | {2'b00, low5}) & mask;
      zero_bank = up & mask;
    endfunction

    function void program_register(cfg_reg_t idx, logic [2:0] val);
      if (idx == REG_ROM_BANKS_LOG2) begin
        banks_log2 = val;
        derive_banks();
      end else begin
        ram_sel = ram_kind_t'(val[1:0]);
      end
    endfunction

    function bit map_ram(input logic [15:0] a, output logic [20:0] ra);
      ra = '0;
      if (!ram_on) return 1'b0;
      case (ram_sel)
        RAM_2K: ra = 21'(a[10:0]);
        RAM_8K: ra = 21'(a[12:0]);
        RAM_32K: ra = mode ? 21'({upper, a[12:0]}) : 21'(a[12:0]);
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_access(logic wr, logic [15:0] a, logic [7:0] d);
      translation_t t;
      logic [20:0]  ra;
      bit           hit;
      bit           ram_window;
      t.kind = KIND_NONE;
      t.addr = '0;
      t.data = '0;
      ram_window = (a >= 16'hA000) && (a <= 16'hBFFF);
      hit = map_ram(a, ra);
      if (wr) begin
        if (a < 16'h2000) begin
          ram_on = (d[3:0] == RAM_ENABLE_KEY);
        end else if (a < 16'h4000) begin
          low5 = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
          derive_banks();
        end else if (a < 16'h6000) begin
          upper = d[1:0];
          derive_banks();
        end else if (a < 16'h8000) begin
          mode = d[0];
        end else if (ram_window && hit) begin
          t.kind = KIND_RAM_WRITE;
          t.addr = ra;
          t.data = d;
        end
      end else begin
        if (a < 16'h4000) begin
          t.kind = KIND_ROM_READ;
          t.addr = {mode ? zero_bank : 7'd0, a[13:0]};
        end else if (a < 16'h8000) begin
          t.kind = KIND_ROM_READ;
          t.addr = {switch_bank, a[13:0]};
        end else if (ram_window && hit) begin
          t.kind = KIND_RAM_READ;
          t.addr = ra;
        end
      end
      expected.push_back(t);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on beat %0d, %s: got 0x%0h, want 0x%0h", checked, what, got, want);
      errors++;
    endtask

    task check_result(access_kind_t kind, logic [20:0] addr, logic [7:0] data);
      translation_t t;
      checked++;
      if (expected.size() == 0) begin
        report("beat with nothing outstanding", 32'(kind), 32'(0));
        return;
      end
      t = expected.pop_front();
      if (kind !== t.kind) report("access_kind", 32'(kind), 32'(t.kind));
      if (addr !== t.addr) report("mapped_address", 32'(addr), 32'(t.addr));
      if (data !== t.data) report("ram_write_byte", 32'(data), 32'(t.data));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // bus_address, write_byte
  logic        s_axis_tuser = 1'b0; // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // mapped_address, ram_write_byte, zero pad
  logic [1:0]  m_axis_tuser;        // access_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [2:0]  cfg_data = '0;

  int src_idle = 19;
  int sink_idle = 71;
  int sent = 0;
  int settings = 0;

  bank_scoreboard sb = new();

  mbc1_bank_mapper #(
    .MAX_ROM_BANKS(ROM_BANK_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(access_kind_t'(m_axis_tuser), m_axis_tdata[20:0], m_axis_tdata[28:21]);
    end
  end

  task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= wr;
    s_axis_tdata <= {d, a};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_access(wr, a, d);
    sent++;
  endtask

  // hold off until every translated beat is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mapping(input logic [2:0] log2, input ram_kind_t ram);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROM_BANKS_LOG2;
    cfg_data <= log2;
    do @(posedge clk); while (!cfg_ready);
    sb.program_register(REG_ROM_BANKS_LOG2, log2);
    cfg_index <= REG_RAM_KIND;
    cfg_data <= 3'(ram);
    do @(posedge clk); while (!cfg_ready);
    sb.program_register(REG_RAM_KIND, 3'(ram));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic pick_access(output logic wr, output logic [15:0] a, output logic [7:0] d);
    int sel;
    sel = $urandom_range(99);
    wr = 1'($urandom_range(1));
    a = 16'($urandom_range(16'hFFFF));
    d = 8'($urandom_range(255));
    if (sel < 12) begin
      wr = 1'b1;
      a = 16'($urandom_range(16'h1FFF));
      if ($urandom_range(3) != 0) d[3:0] = RAM_ENABLE_KEY;
    end else if (sel < 24) begin
      wr = 1'b1;
      a = 16'($urandom_range(16'h3FFF, 16'h2000));
      if ($urandom_range(7) == 0) d[4:0] = 5'd0;
    end else if (sel < 32) begin
      wr = 1'b1;
      a = 16'($urandom_range(16'h5FFF, 16'h4000));
    end else if (sel < 38) begin
      wr = 1'b1;
      a = 16'($urandom_range(16'h7FFF, 16'h6000));
    end else if (sel < 65) begin
      wr = 1'b0;
      a = 16'($urandom_range(16'h7FFF));
    end else if (sel < 90) begin
      a = 16'($urandom_range(16'hBFFF, 16'hA000));
    end
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int        log2_plan[8] = '{7, 0, 1, 3, 5, 2, 6, 4};
    ram_kind_t ram_plan[8] = '{RAM_32K, RAM_2K, RAM_8K, RAM_NONE, RAM_32K, RAM_32K, RAM_8K,
                               RAM_2K};
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset mapping: two banks, no ram
    send_access(1'b0, 16'h0000, 8'h00);
    send_access(1'b0, 16'h7FFF, 8'hFF);
    send_access(1'b1, 16'h0000, 8'h0A);
    send_access(1'b0, 16'hA000, 8'h00);
    send_access(1'b1, 16'h2000, 8'h00);
    send_access(1'b0, 16'h4000, 8'h00);
    drain();

    set_mapping(3'd7, RAM_32K);
    send_access(1'b1, 16'h0000, 8'h0A);
    send_access(1'b1, 16'h2000, 8'hE0);
    send_access(1'b0, 16'h4000, 8'h00);
    send_access(1'b1, 16'h3FFF, 8'h1F);
    send_access(1'b1, 16'h4000, 8'hFF);
    send_access(1'b1, 16'h6000, 8'h01);
    send_access(1'b0, 16'h0000, 8'hFF);
    send_access(1'b0, 16'h3FFF, 8'h00);
    send_access(1'b0, 16'h7FFF, 8'h00);
    send_access(1'b1, 16'hA000, 8'hFF);
    send_access(1'b0, 16'hBFFF, 8'h00);
    send_access(1'b1, 16'h8000, 8'h55);
    send_access(1'b0, 16'h9FFF, 8'h00);
    send_access(1'b0, 16'hC000, 8'h00);
    send_access(1'b1, 16'hFFFF, 8'hAA);
    send_access(1'b1, 16'h7FFF, 8'hFE);
    send_access(1'b1, 16'hBFFF, 8'h81);
    send_access(1'b1, 16'h1FFF, 8'hFA);
    send_access(1'b1, 16'h0000, 8'h00);
    send_access(1'b0, 16'hA000, 8'h00);

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        src_idle = 19;
        sink_idle = 71;
      end else if (p < 6) begin
        src_idle = 71;
        sink_idle = 19;
      end else begin
        src_idle = 0;
        sink_idle = 0;
      end
      drain();
      set_mapping(3'(log2_plan[p]), ram_plan[p]);
      for (int i = 0; i < 50; i++) begin
        if (i == 25) drain();
        pick_access(wr, a, d);
        send_access(wr, a, d);
      end
    end

    drain();
    $display("%0d bus accesses sent and %0d translated beats checked", sent, sb.checked);
    $display("%0d bank and ram settings, three handshake pacing profiles", settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
